// ===== hdl/assert_macros.svh =====
// assertion macros used by the page read cache directory controller
// assumes clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hdl/prc_pkg.sv =====
// types and constants of the page read cache directory
// no dependencies
`timescale 1ns / 1ps
package prc_pkg;
  localparam int CACHE_SLOTS = 16;
  localparam int FILE_SLOTS  = 8;
  localparam int PAGE_BITS   = 20;
  localparam int SLOT_W      = $clog2(CACHE_SLOTS);
  localparam int FILE_W      = 3;
  localparam int END_W       = PAGE_BITS + 1;
  localparam int STAMP_W     = 32;
  localparam int GRP_SIZE    = 4;
  localparam int GROUPS      = CACHE_SLOTS / GRP_SIZE;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PAGE   = 3'd1,
    ST_ALREADY    = 3'd2,
    ST_NOT_OPEN_C = 3'd3,
    ST_NOT_OPEN   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL
  } state_e;

  typedef struct packed {
    op_e                  mode;
    logic [FILE_W-1:0]    file_id;
    logic [PAGE_BITS-1:0] page;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic                 hit;
    logic                 fill;
    logic [SLOT_W-1:0]    slot;
    logic [END_W-1:0]     end_page;
  } out_item_t;

  typedef struct packed {
    logic load_req;
    logic load_cmp;
    logic commit;
  } prc_cmd_t;
endpackage

// ===== hdl/page_read_cache_lru_directory.sv =====
// top level of the page read cache directory
// depends on prc_pkg, prc_ctrl and prc_dpath
`timescale 1ns / 1ps
// Directory of a 16-slot fully associative page read cache with LRU by stamp.
// Input channel in_valid_i/in_ready_o carries in_item_i (mode, file_id, page):
// open, close, write page or read page. Output channel out_valid_o/out_ready_i
// carries out_item_o (status, hit, fill, slot, end_page), one result per item.
// A read hit refreshes the slot stamp; a read miss claims the first free slot,
// else the oldest one, and reports it as a fill. Page data is handled outside.
// Timing: an item is taken in the idle state, tags and per-group oldest stamps
// are compared and registered in the compare state, and the final victim choice
// plus the state update happen in the select state, which loads the result
// register. A new item is taken only in the idle state, after the last one has
// been committed. The compare and select states are set by the two-level
// registered oldest-stamp search.
// A finished result waits in its register while the next item is taken; if it
// is still not taken when the next result is ready, the block holds there.
// Reset empties all slots, closes all files and sets the access clock to one;
// no clearing pass is needed.
module page_read_cache_lru_directory
  import prc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);
  prc_cmd_t cmd;

  prc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  prc_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .out_item_o (out_item_o)
  );
endmodule

// ===== hdl/prc_ctrl.sv =====
// controller of the page read cache directory: sequencing and output valid
// depends on prc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prc_ctrl
  import prc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output prc_cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CMP;
      S_CMP:  state_d = S_SEL;
      S_SEL:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    cmd_o.load_req = in_ready_o && in_valid_i;
    cmd_o.load_cmp = (state_q == S_CMP);
    cmd_o.commit   = (state_q == S_SEL) && out_free;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_PROP(a_accept_to_cmp, (in_valid_i && in_ready_o) |=> (state_q == S_CMP), "accept must start compare")
  `ASSERT_NEVER(a_commit_overwrite, cmd_o.commit && out_valid_q && !out_ready_i, "result overwritten")
  `ASSERT_PROP(a_rose_after_sel, $rose(out_valid_o) |-> ($past(state_q) == S_SEL), "result without commit")
endmodule

// ===== hdl/prc_dpath.sv =====
// datapath of the page read cache directory: tags, stamps, file table, lru search
// depends on prc_pkg
`timescale 1ns / 1ps
module prc_dpath
  import prc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  prc_cmd_t  cmd_i,
  output out_item_t out_item_o
);
  localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

  in_item_t             req_q;
  logic [CACHE_SLOTS-1:0] valid_q;
  logic [FILE_W-1:0]    file_q  [CACHE_SLOTS];
  logic [PAGE_BITS-1:0] page_q  [CACHE_SLOTS];
  logic [STAMP_W-1:0]   stamp_q [CACHE_SLOTS];
  logic [STAMP_W-1:0]   clock_q;
  logic [FILE_SLOTS-1:0] open_q;
  logic [END_W-1:0]     end_q   [FILE_SLOTS];

  // compare stage results
  logic [CACHE_SLOTS-1:0] match_q, match_d;
  logic [CACHE_SLOTS-1:0] inv_q, inv_d;
  logic [STAMP_W-1:0]   gstamp_q [GROUPS];
  logic [STAMP_W-1:0]   gstamp_d [GROUPS];
  logic [SLOT_W-1:0]    gidx_q   [GROUPS];
  logic [SLOT_W-1:0]    gidx_d   [GROUPS];

  out_item_t            out_q, out_d;

  // compare stage: tag match and per-group oldest slot
  always_comb begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      match_d[i] = valid_q[i] && (file_q[i] == req_q.file_id) && (page_q[i] == req_q.page);
      inv_d[i]   = !valid_q[i];
    end
    for (int g = 0; g < GROUPS; g++) begin
      gstamp_d[g] = stamp_q[g*GRP_SIZE];
      gidx_d[g]   = SLOT_W'(g*GRP_SIZE);
      for (int j = 1; j < GRP_SIZE; j++) begin
        if (stamp_q[g*GRP_SIZE+j] < gstamp_d[g]) begin
          gstamp_d[g] = stamp_q[g*GRP_SIZE+j];
          gidx_d[g]   = SLOT_W'(g*GRP_SIZE+j);
        end
      end
    end
  end

  // select stage
  logic                 in_range, is_open, hit, page_ok;
  logic [SLOT_W-1:0]    hit_idx, inv_idx, lru_idx, victim;
  logic [STAMP_W-1:0]   lru_stamp, clock_nx;
  logic [END_W-1:0]     cur_end, page_ext;
  logic [FILE_W-1:0]    f;
  logic                 do_open, do_close, do_write, do_hit, do_fill, grow;

  always_comb begin
    f        = req_q.file_id;
    in_range = ({1'b0, f} < (FILE_W+1)'(FILE_SLOTS));
    is_open  = in_range && open_q[f];
    cur_end  = in_range ? end_q[f] : '0;
    page_ext = {1'b0, req_q.page};
    page_ok  = page_ext < cur_end;
    clock_nx = (clock_q == CLOCK_MAX) ? clock_q : clock_q + STAMP_W'(1);
    hit      = |match_q;
    hit_idx  = '0;
    for (int i = CACHE_SLOTS-1; i >= 0; i--) if (match_q[i]) hit_idx = SLOT_W'(i);
    inv_idx  = '0;
    for (int i = CACHE_SLOTS-1; i >= 0; i--) if (inv_q[i]) inv_idx = SLOT_W'(i);
    lru_stamp = gstamp_q[0];
    lru_idx   = gidx_q[0];
    for (int g = 1; g < GROUPS; g++) begin
      if (gstamp_q[g] < lru_stamp) begin
        lru_stamp = gstamp_q[g];
        lru_idx   = gidx_q[g];
      end
    end
    victim   = (|inv_q) ? inv_idx : lru_idx;
    grow     = !page_ok;

    do_open  = 1'b0;
    do_close = 1'b0;
    do_write = 1'b0;
    do_hit   = 1'b0;
    do_fill  = 1'b0;
    out_d.status   = ST_OK;
    out_d.hit      = 1'b0;
    out_d.fill     = 1'b0;
    out_d.slot     = '0;
    out_d.end_page = cur_end;
    unique case (req_q.mode)
      OP_OPEN: begin
        if (!in_range) out_d.status = ST_NOT_OPEN;
        else if (is_open) out_d.status = ST_ALREADY;
        else begin
          do_open = 1'b1;
          out_d.end_page = page_ext;
        end
      end
      OP_CLOSE: begin
        if (!is_open) out_d.status = ST_NOT_OPEN_C;
        else begin
          do_close = 1'b1;
          out_d.end_page = '0;
        end
      end
      OP_WRITE: begin
        if (!is_open) out_d.status = ST_NOT_OPEN;
        else begin
          do_write = 1'b1;
          if (grow) out_d.end_page = page_ext + END_W'(1);
        end
      end
      OP_READ: begin
        if (!is_open) out_d.status = ST_NOT_OPEN;
        else if (!page_ok) out_d.status = ST_BAD_PAGE;
        else if (hit) begin
          do_hit     = 1'b1;
          out_d.hit  = 1'b1;
          out_d.slot = hit_idx;
        end else begin
          do_fill    = 1'b1;
          out_d.fill = 1'b1;
          out_d.slot = victim;
        end
      end
      default: out_d.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_item_i;
    if (cmd_i.load_cmp) begin
      match_q  <= match_d;
      inv_q    <= inv_d;
      gstamp_q <= gstamp_d;
      gidx_q   <= gidx_d;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
      if (do_hit) stamp_q[hit_idx] <= clock_nx;
      if (do_fill) begin
        file_q[victim]  <= f;
        page_q[victim]  <= req_q.page;
        stamp_q[victim] <= clock_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clock_q <= STAMP_W'(1);
      open_q  <= '0;
      for (int k = 0; k < FILE_SLOTS; k++) end_q[k] <= '0;
    end else if (cmd_i.commit) begin
      if (do_open) begin
        open_q[f] <= 1'b1;
        end_q[f]  <= page_ext;
      end
      if (do_close) begin
        for (int i = 0; i < CACHE_SLOTS; i++)
          if (file_q[i] == f) valid_q[i] <= 1'b0;
        open_q[f] <= 1'b0;
        end_q[f]  <= '0;
      end
      if (do_write) begin
        valid_q <= valid_q & ~match_q;
        if (grow) end_q[f] <= page_ext + END_W'(1);
      end
      if (do_hit) clock_q <= clock_nx;
      if (do_fill) begin
        valid_q[victim] <= 1'b1;
        clock_q         <= clock_nx;
      end
    end
  end

  assign out_item_o = out_q;
endmodule
